@@ src/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// CEC frame receiver package
// Shared word types, phase codes, timing windows and frame-size constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int MAX_FRAME_BYTES = 16;
  localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_LOW  = 4'd1;
  localparam logic [3:0] PH_START_HIGH = 4'd2;
  localparam logic [3:0] PH_DATA_LOW   = 4'd3;
  localparam logic [3:0] PH_DATA_HIGH  = 4'd4;
  localparam logic [3:0] PH_EOM_LOW    = 4'd5;
  localparam logic [3:0] PH_EOM_HIGH   = 4'd6;
  localparam logic [3:0] PH_ACK_LOW    = 4'd7;
  localparam logic [3:0] PH_ACK_HIGH   = 4'd8;
  localparam logic [3:0] PH_ACK_END    = 4'd9;
  localparam logic [3:0] PH_DONE       = 4'd10;
  localparam logic [3:0] PH_ABORT      = 4'd11;

  localparam logic       CMD_ARM  = 1'b0;
  localparam logic       CMD_EDGE = 1'b1;

  localparam logic [31:0] START_LOW_MIN   = 32'd3500;
  localparam logic [31:0] START_LOW_MAX   = 32'd3900;
  localparam logic [31:0] FIRST_BIT_MIN   = 32'd4300;
  localparam logic [31:0] FIRST_BIT_MAX   = 32'd4700;
  localparam logic [31:0] BIT_PERIOD_MIN  = 32'd2050;
  localparam logic [31:0] BIT_PERIOD_MAX  = 32'd2750;
  localparam logic [31:0] ONE_LOW_MIN     = 32'd400;
  localparam logic [31:0] ONE_LOW_MAX     = 32'd800;
  localparam logic [31:0] ZERO_LOW_MIN    = 32'd1300;
  localparam logic [31:0] ZERO_LOW_MAX    = 32'd1700;
  localparam logic [31:0] ACK_HOLD_US     = 32'd1500;
  localparam logic [3:0]  BROADCAST_ADDR  = 4'hf;

  typedef struct packed {
    logic        command;
    logic        edge_rising;
    logic [31:0] timestamp_us;
  } cfr_in_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [3:0]  byte_index;
    logic        drive_ack;
    logic [31:0] ack_release_time;
    logic        frame_done;
    logic        frame_aborted;
    logic [4:0]  frame_length;
    logic        acked;
  } cfr_out_t;

  typedef struct packed {
    logic [3:0]         phase;
    logic [31:0]        mark_time;
    logic               first_bit_pending;
    logic [COUNT_W-1:0] byte_count;
    logic [3:0]         bit_count;
    logic [7:0]         shift_value;
    logic [3:0]         header_dest;
    logic               end_of_message;
    logic               ack_given;
  } cfr_state_t;

endpackage

`default_nettype wire

@@ src/cfr_step.sv @@
// ----------------------------------------------------------------------------
// CEC frame receiver step logic
// Computes the next receiver state and the result word for one edge or arm.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_step
  import cfr_pkg::*;
(
  input  wire cfr_state_t st,
  input  wire cfr_in_t    in_word,
  input  wire [3:0]       own_address,
  output cfr_state_t      st_nxt,
  output logic            emit,
  output cfr_out_t        res
);

  logic [31:0]        dt;
  logic               is_one;
  logic               is_zero;
  logic               rising;
  logic [3:0]         bits_nxt;
  logic [7:0]         shift_nxt;
  logic               period_ok;

  assign dt        = in_word.timestamp_us - st.mark_time;
  assign rising    = in_word.edge_rising;
  assign is_one    = (dt >= ONE_LOW_MIN) && (dt <= ONE_LOW_MAX);
  assign is_zero   = (dt >= ZERO_LOW_MIN) && (dt <= ZERO_LOW_MAX);
  assign bits_nxt  = st.bit_count + 4'd1;
  assign shift_nxt = {st.shift_value[6:0], is_one};
  assign period_ok = st.first_bit_pending ?
                     ((dt >= FIRST_BIT_MIN) && (dt <= FIRST_BIT_MAX)) :
                     ((dt >= BIT_PERIOD_MIN) && (dt <= BIT_PERIOD_MAX));

  always_comb begin
    st_nxt = st;
    res    = '0;
    emit   = 1'b0;
    if (in_word.command == CMD_ARM) begin
      st_nxt       = '0;
      st_nxt.phase = PH_START_LOW;
    end else begin
      unique case (st.phase)
        PH_START_LOW: begin
          if (!rising) begin
            st_nxt.mark_time = in_word.timestamp_us;
            st_nxt.phase     = PH_START_HIGH;
          end
        end
        PH_START_HIGH: begin
          if (rising) begin
            if ((dt >= START_LOW_MIN) && (dt <= START_LOW_MAX)) begin
              st_nxt.first_bit_pending = 1'b1;
              st_nxt.byte_count        = '0;
              st_nxt.bit_count         = '0;
              st_nxt.phase             = PH_DATA_LOW;
            end else begin
              st_nxt.phase      = PH_ABORT;
              res.frame_aborted = 1'b1;
              emit              = 1'b1;
            end
          end
        end
        PH_DATA_LOW, PH_EOM_LOW: begin
          if (!rising) begin
            if ((st.phase == PH_DATA_LOW) && (st.bit_count == 4'd0) &&
                (st.byte_count >= COUNT_W'(MAX_FRAME_BYTES))) begin
              st_nxt.phase      = PH_ABORT;
              res.frame_aborted = 1'b1;
              emit              = 1'b1;
            end else if (period_ok) begin
              st_nxt.mark_time         = in_word.timestamp_us;
              st_nxt.first_bit_pending = 1'b0;
              st_nxt.phase = (st.phase == PH_EOM_LOW) ? PH_EOM_HIGH : PH_DATA_HIGH;
            end else begin
              st_nxt.phase      = PH_ABORT;
              res.frame_aborted = 1'b1;
              emit              = 1'b1;
            end
          end
        end
        PH_DATA_HIGH, PH_EOM_HIGH: begin
          if (rising) begin
            if (!is_one && !is_zero) begin
              st_nxt.phase      = PH_ABORT;
              res.frame_aborted = 1'b1;
              emit              = 1'b1;
            end else if (st.phase == PH_EOM_HIGH) begin
              st_nxt.end_of_message = is_one;
              st_nxt.phase          = PH_ACK_LOW;
            end else if (bits_nxt >= 4'd8) begin
              res.byte_valid = 1'b1;
              res.byte_value = shift_nxt;
              res.byte_index = 4'(st.byte_count);
              emit           = 1'b1;
              if (st.byte_count == '0) begin
                st_nxt.header_dest = shift_nxt[3:0];
              end
              st_nxt.byte_count  = st.byte_count + COUNT_W'(1);
              st_nxt.bit_count   = '0;
              st_nxt.shift_value = '0;
              st_nxt.phase       = PH_EOM_LOW;
            end else begin
              st_nxt.shift_value = shift_nxt;
              st_nxt.bit_count   = bits_nxt;
              st_nxt.phase       = PH_DATA_LOW;
            end
          end
        end
        PH_ACK_LOW: begin
          if (!rising) begin
            st_nxt.mark_time = in_word.timestamp_us;
            if ((st.header_dest != BROADCAST_ADDR) && (st.header_dest == own_address)) begin
              st_nxt.ack_given     = 1'b1;
              res.drive_ack        = 1'b1;
              res.ack_release_time = in_word.timestamp_us + ACK_HOLD_US;
              emit                 = 1'b1;
              st_nxt.phase         = PH_ACK_END;
            end else begin
              st_nxt.phase = PH_ACK_HIGH;
            end
          end
        end
        PH_ACK_HIGH, PH_ACK_END: begin
          if (rising) begin
            if ((st.phase == PH_ACK_HIGH) && !is_one && !is_zero) begin
              st_nxt.phase      = PH_ABORT;
              res.frame_aborted = 1'b1;
              emit              = 1'b1;
            end else if (st.end_of_message) begin
              st_nxt.phase     = PH_DONE;
              res.frame_done   = 1'b1;
              res.frame_length = 5'(st.byte_count);
              emit             = 1'b1;
            end else begin
              st_nxt.phase = PH_DATA_LOW;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.acked = st_nxt.ack_given;
  end

endmodule

`default_nettype wire

@@ src/cec_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// CEC frame receiver core
// Decodes a single-wire CEC frame from timestamped line edges, one word per
// edge, and reports completed bytes, ack requests and the end of the frame.
// ----------------------------------------------------------------------------
//   Channel  Ports                         Word
//   input    in_valid / in_ready           cfr_in_t  (command, edge, timestamp)
//   result   out_valid / out_ready         cfr_out_t (byte, ack, frame status)
//   config   cfg_we / cfg_wdata            own address, 4 bits
//
// The step logic updates the frame state and writes the result register
// on the accepting edge.
// A new word is accepted every cycle while the result register is empty or
// being taken; only a stalled result holds off input.
// Words that cause no result leave the result register untouched.
// Reset clears the frame state to idle and the own address to 15.
// ----------------------------------------------------------------------------
`default_nettype none

module cec_frame_receiver_core
  import cfr_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire cfr_in_t in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output cfr_out_t  out_data,
  input  wire       cfg_we,
  input  wire [3:0] cfg_wdata
);

  cfr_state_t st_r;
  cfr_state_t st_nxt;
  cfr_out_t   res;
  cfr_out_t   out_data_r;
  logic       out_valid_r;
  logic [3:0] own_address_r;
  logic       emit;
  logic       in_fire;

  cfr_step u_step (
    .st          (st_r),
    .in_word     (in_data),
    .own_address (own_address_r),
    .st_nxt      (st_nxt),
    .emit        (emit),
    .res         (res)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= '0;
      out_valid_r   <= 1'b0;
      own_address_r <= BROADCAST_ADDR;
    end else begin
      if (cfg_we) begin
        own_address_r <= cfg_wdata;
      end
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data_r <= res;
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit |=> out_valid_r)
    else $error("result was not presented");

  a_abort_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit && res.frame_aborted |=> st_r.phase == PH_ABORT)
    else $error("abort did not reach abort phase");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit && res.frame_done |=> st_r.phase == PH_DONE)
    else $error("frame end did not reach done phase");

  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.frame_done && out_data_r.frame_aborted))
    else $error("frame both done and aborted");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_count <= COUNT_W'(MAX_FRAME_BYTES))
    else $error("byte count beyond frame limit");

endmodule

`default_nettype wire

@@ tb/cec_frame_receiver_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CEC frame receiver core testbench
// Drives armed CEC frames as timestamped edge words, with boundary and
// out-of-window timings, stray edges and changes of the own address. A
// scoreboard predicts every result word and checks the block's output
// against it.
// ----------------------------------------------------------------------------

module cec_frame_receiver_core_tb;
  import cfr_pkg::*;

  localparam int LOW_ZERO = 0;
  localparam int LOW_ONE = 1;
  localparam int LOW_BAD = 2;

  localparam logic EDGE_FALL = 1'b0;
  localparam logic EDGE_RISE = 1'b1;

  localparam int RESET_CYCLES = 12;
  localparam int IDLE_MAX = 13;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 750;

  class cec_rx_scoreboard;
    logic [3:0] own_addr;
    logic [3:0] phase;
    logic [31:0] mark_time;
    logic first_pending;
    logic [COUNT_W-1:0] byte_count;
    logic [3:0] bit_count;
    logic [7:0] shifter;
    logic [3:0] dest;
    logic eom;
    logic ack_given;
    cfr_out_t due_words[$];
    int errors;

    function new();
      own_addr = BROADCAST_ADDR;
      phase = PH_IDLE;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      mark_time = '0;
      first_pending = 1'b0;
      byte_count = '0;
      bit_count = '0;
      shifter = '0;
      dest = '0;
      eom = 1'b0;
      ack_given = 1'b0;
    endfunction

    function int classify_low(logic [31:0] v);
      if (v >= ONE_LOW_MIN && v <= ONE_LOW_MAX) return LOW_ONE;
      if (v >= ZERO_LOW_MIN && v <= ZERO_LOW_MAX) return LOW_ZERO;
      return LOW_BAD;
    endfunction

    function void note_word(cfr_in_t w);
      cfr_out_t r;
      bit emit;
      bit period_ok;
      logic [31:0] dt;
      int low_kind;
      r = '0;
      emit = 1'b0;
      dt = w.timestamp_us - mark_time;
      low_kind = classify_low(dt);
      if (w.command == CMD_ARM) begin
        clear_frame();
        phase = PH_START_LOW;
        return;
      end
      case (phase)
        PH_START_LOW: begin
          if (w.edge_rising == EDGE_FALL) begin
            mark_time = w.timestamp_us;
            phase = PH_START_HIGH;
          end
        end
        PH_START_HIGH: begin
          if (w.edge_rising == EDGE_RISE) begin
            if (dt >= START_LOW_MIN && dt <= START_LOW_MAX) begin
              first_pending = 1'b1;
              byte_count = '0;
              bit_count = '0;
              phase = PH_DATA_LOW;
            end else begin
              phase = PH_ABORT;
              r.frame_aborted = 1'b1;
              emit = 1'b1;
            end
          end
        end
        PH_DATA_LOW, PH_EOM_LOW: begin
          if (w.edge_rising == EDGE_FALL) begin
            period_ok = first_pending ? (dt >= FIRST_BIT_MIN && dt <= FIRST_BIT_MAX)
                                      : (dt >= BIT_PERIOD_MIN && dt <= BIT_PERIOD_MAX);
            if (phase == PH_DATA_LOW && bit_count == 0 && byte_count >= MAX_FRAME_BYTES) begin
              phase = PH_ABORT;
              r.frame_aborted = 1'b1;
              emit = 1'b1;
            end else if (period_ok) begin
              mark_time = w.timestamp_us;
              phase = (phase == PH_EOM_LOW) ? PH_EOM_HIGH : PH_DATA_HIGH;
              first_pending = 1'b0;
            end else begin
              phase = PH_ABORT;
              r.frame_aborted = 1'b1;
              emit = 1'b1;
            end
          end
        end
        PH_DATA_HIGH, PH_EOM_HIGH: begin
          if (w.edge_rising == EDGE_RISE) begin
            if (low_kind == LOW_BAD) begin
              phase = PH_ABORT;
              r.frame_aborted = 1'b1;
              emit = 1'b1;
            end else if (phase == PH_EOM_HIGH) begin
              eom = (low_kind == LOW_ONE);
              phase = PH_ACK_LOW;
            end else begin
              shifter = {shifter[6:0], low_kind == LOW_ONE};
              bit_count = bit_count + 1'b1;
              if (bit_count >= 8) begin
                r.byte_valid = 1'b1;
                r.byte_value = shifter;
                r.byte_index = byte_count[3:0];
                emit = 1'b1;
                if (byte_count == 0) dest = shifter[3:0];
                byte_count = byte_count + 1'b1;
                bit_count = '0;
                shifter = '0;
                phase = PH_EOM_LOW;
              end else begin
                phase = PH_DATA_LOW;
              end
            end
          end
        end
        PH_ACK_LOW: begin
          if (w.edge_rising == EDGE_FALL) begin
            mark_time = w.timestamp_us;
            if (dest != BROADCAST_ADDR && dest == own_addr) begin
              ack_given = 1'b1;
              r.drive_ack = 1'b1;
              r.ack_release_time = w.timestamp_us + ACK_HOLD_US;
              emit = 1'b1;
              phase = PH_ACK_END;
            end else begin
              phase = PH_ACK_HIGH;
            end
          end
        end
        PH_ACK_HIGH, PH_ACK_END: begin
          if (w.edge_rising == EDGE_RISE) begin
            if (phase == PH_ACK_HIGH && low_kind == LOW_BAD) begin
              phase = PH_ABORT;
              r.frame_aborted = 1'b1;
              emit = 1'b1;
            end else if (eom) begin
              phase = PH_DONE;
              r.frame_done = 1'b1;
              r.frame_length = 5'(byte_count);
              emit = 1'b1;
            end else begin
              phase = PH_DATA_LOW;
            end
          end
        end
        default: begin
        end
      endcase
      if (emit) begin
        r.acked = ack_given;
        due_words.push_back(r);
      end
    endfunction

    function string show(cfr_out_t v);
      return $sformatf({"byte_valid=%0d byte_value=%02h byte_index=%0d drive_ack=%0d ",
                        "release=%08h done=%0d aborted=%0d length=%0d acked=%0d"},
                       v.byte_valid, v.byte_value, v.byte_index, v.drive_ack,
                       v.ack_release_time, v.frame_done, v.frame_aborted,
                       v.frame_length, v.acked);
    endfunction

    function void check_report(cfr_out_t got);
      cfr_out_t want;
      bit bad;
      if (due_words.size() == 0) begin
        if (errors < 10) $display("Unexpected result word: %s", show(got));
        errors++;
        return;
      end
      want = due_words.pop_front();
      bad = 1'b0;
      bad |= (got.byte_valid !== want.byte_valid);
      bad |= (got.byte_value !== want.byte_value);
      bad |= (got.byte_index !== want.byte_index);
      bad |= (got.drive_ack !== want.drive_ack);
      bad |= (got.ack_release_time !== want.ack_release_time);
      bad |= (got.frame_done !== want.frame_done);
      bad |= (got.frame_aborted !== want.frame_aborted);
      bad |= (got.frame_length !== want.frame_length);
      bad |= (got.acked !== want.acked);
      if (bad) begin
        if (errors < 10) begin
          $display("Result mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cfr_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cfr_out_t out_data;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  cec_rx_scoreboard sb;
  bit quiet = 1'b0;
  bit noisy = 1'b0;
  int lead_gap = 0;
  int words_sent = 0;
  int idle_cycles = 0;

  cec_frame_receiver_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_idle();
    return quiet ? 0 : $urandom_range(IDLE_MAX, 0);
  endfunction

  function automatic logic [31:0] pick_time(input logic [31:0] lo, input logic [31:0] hi);
    if (noisy && $urandom_range(29, 0) == 0) begin
      case ($urandom_range(2, 0))
        0: return lo - 1;
        1: return hi + 1;
        default: return $urandom();
      endcase
    end
    case ($urandom_range(5, 0))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [31:0] pulse_width(input logic one);
    return one ? pick_time(ONE_LOW_MIN, ONE_LOW_MAX) : pick_time(ZERO_LOW_MIN, ZERO_LOW_MAX);
  endfunction

  task automatic send_word(input logic cmd, input logic rising, input logic [31:0] ts);
    cfr_in_t w;
    w.command = cmd;
    w.edge_rising = rising;
    w.timestamp_us = ts;
    if (lead_gap > 0) repeat (lead_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
    lead_gap = draw_idle();
    if (lead_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic line_edge(input logic rising, input logic [31:0] ts);
    if ($urandom_range(24, 0) == 0) send_word(CMD_EDGE, ~rising, $urandom());
    send_word(CMD_EDGE, rising, ts);
  endtask

  task automatic park_input();
    if (lead_gap == 0) in_valid <= 1'b0;
  endtask

  task automatic set_own_address(input logic [3:0] addr);
    park_input();
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    sb.own_addr = addr;
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame(input int nbytes, input logic [31:0] t0);
    logic [31:0] fall;
    logic [7:0] value;
    logic one;
    send_word(CMD_ARM, 1'($urandom_range(1, 0)), $urandom());
    fall = t0;
    line_edge(EDGE_FALL, fall);
    line_edge(EDGE_RISE, fall + pick_time(START_LOW_MIN, START_LOW_MAX));
    if (sb.phase == PH_ABORT) return;
    fall += pick_time(FIRST_BIT_MIN, FIRST_BIT_MAX);
    for (int i = 0; i < nbytes; i++) begin
      value = 8'($urandom());
      if (i == 0 && $urandom_range(1, 0) == 1) value[3:0] = sb.own_addr;
      // Steps 0..7 are the data bits, 8 the end-of-message bit, 9 the ack bit.
      for (int k = 0; k <= 9; k++) begin
        if (k < 8) one = value[7 - k];
        else if (k == 8) one = (i == nbytes - 1);
        else one = 1'($urandom_range(1, 0));
        if ($urandom_range(299, 0) == 0) return;
        line_edge(EDGE_FALL, fall);
        if (sb.phase == PH_ABORT) return;
        if (sb.phase == PH_ACK_END)
          line_edge(EDGE_RISE, $urandom_range(1, 0) ? fall + ACK_HOLD_US : $urandom());
        else
          line_edge(EDGE_RISE, fall + pulse_width(one));
        if (sb.phase == PH_ABORT) return;
        fall += (k == 8) ? 32'($urandom_range(8000, 0)) : pick_time(BIT_PERIOD_MIN, BIT_PERIOD_MAX);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_report(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int frame_no;
    int nbytes;
    int start_count;
    logic [31:0] fall;
    logic [31:0] base;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edges while idle, then a start bit that is too short.
    send_word(CMD_EDGE, EDGE_FALL, 32'h0000_0000);
    send_word(CMD_EDGE, EDGE_RISE, 32'hFFFF_FFFF);
    send_word(CMD_ARM, EDGE_RISE, 32'hFFFF_FFFF);
    send_word(CMD_EDGE, EDGE_RISE, 32'h0001_2345);
    send_word(CMD_EDGE, EDGE_FALL, 32'hFFFF_F000);
    send_word(CMD_EDGE, EDGE_FALL, 32'h0000_0000);
    send_word(CMD_EDGE, EDGE_RISE, 32'hFFFF_F000 + START_LOW_MIN - 1);
    send_word(CMD_EDGE, EDGE_FALL, 32'h0000_0000);

    // Window edges across the timestamp wrap, then a bit period one too long.
    fall = 32'hFFFF_FF00;
    send_word(CMD_ARM, EDGE_FALL, 32'h0000_0000);
    send_word(CMD_EDGE, EDGE_FALL, fall);
    send_word(CMD_EDGE, EDGE_RISE, fall + START_LOW_MAX);
    fall += FIRST_BIT_MIN;
    send_word(CMD_EDGE, EDGE_FALL, fall);
    send_word(CMD_EDGE, EDGE_RISE, fall + ONE_LOW_MAX);
    fall += BIT_PERIOD_MAX;
    send_word(CMD_EDGE, EDGE_FALL, fall);
    send_word(CMD_EDGE, EDGE_RISE, fall + ZERO_LOW_MIN);
    fall += BIT_PERIOD_MIN;
    send_word(CMD_EDGE, EDGE_FALL, fall);
    send_word(CMD_EDGE, EDGE_RISE, fall + ZERO_LOW_MAX);
    send_word(CMD_EDGE, EDGE_FALL, fall + BIT_PERIOD_MAX + 1);

    // First bit period too long, then start bit too long.
    send_word(CMD_ARM, EDGE_RISE, 32'h0000_0000);
    send_word(CMD_EDGE, EDGE_FALL, 32'd1000);
    send_word(CMD_EDGE, EDGE_RISE, 32'd1000 + START_LOW_MIN);
    send_word(CMD_EDGE, EDGE_FALL, 32'd1000 + FIRST_BIT_MAX + 1);
    send_word(CMD_ARM, EDGE_FALL, 32'hFFFF_FFFF);
    send_word(CMD_EDGE, EDGE_FALL, 32'h0000_0000);
    send_word(CMD_EDGE, EDGE_RISE, START_LOW_MAX + 1);

    set_own_address(4'h0);
    frame_no = 0;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      if (frame_no % 4 == 3) begin
        if (frame_no % 16 == 7) set_own_address(BROADCAST_ADDR);
        else set_own_address(4'($urandom_range(15, 0)));
      end
      quiet = ($urandom_range(4, 0) == 0);
      if (frame_no == 2) nbytes = MAX_FRAME_BYTES + 1;
      else if (frame_no == 5) nbytes = MAX_FRAME_BYTES;
      else nbytes = $urandom_range(3, 1);
      noisy = (nbytes <= 3) && ($urandom_range(3, 0) == 0);
      if ($urandom_range(3, 0) == 0) base = 32'hFFFF_F000 + $urandom_range(4095, 0);
      else base = $urandom();
      run_frame(nbytes, base);
      if ($urandom_range(3, 0) == 0) send_word(CMD_EDGE, 1'($urandom_range(1, 0)), $urandom());
      frame_no++;
    end

    park_input();
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
